[src/mppt_pkg.sv]
`default_nettype none
package mppt_pkg;

  localparam int unsigned ADC_BITS_DEF       = 12;
  localparam int unsigned DUTY_BITS_DEF      = 16;
  localparam int unsigned GAIN_FRAC_BITS_DEF = 12;

  localparam int unsigned MEAS_W  = 16;
  localparam int unsigned POWER_W = 32;
  localparam int unsigned NET_W   = 17;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_PANEL_V_GAIN    = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_BATLOAD_V_GAIN  = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_CURRENT_GAIN    = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_BATTERY_V_LIMIT = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_BATTERY_I_LIMIT = REG_IDX_W'(4);
  localparam logic [REG_IDX_W-1:0] REG_CHARGE_INHIBIT  = REG_IDX_W'(5);

  localparam logic [MEAS_W-1:0] GAIN_RESET  = MEAS_W'(4096);
  localparam logic [MEAS_W-1:0] LIMIT_RESET = '1;

  typedef struct packed {
    logic [MEAS_W-1:0] panel_v_gain;
    logic [MEAS_W-1:0] batload_v_gain;
    logic [MEAS_W-1:0] current_gain;
    logic [MEAS_W-1:0] battery_v_limit;
    logic [MEAS_W-1:0] battery_i_limit;
  } mppt_cfg_t;

endpackage
`default_nettype wire

[src/mppt_front.sv]
`default_nettype none
module mppt_front #(
  parameter int unsigned ADC_BITS = mppt_pkg::ADC_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  logic [ADC_BITS-1:0]   panel_v_raw_i,
  input  logic [ADC_BITS-1:0]   panel_i_raw_i,
  input  logic [ADC_BITS-1:0]   batload_v_raw_i,
  input  logic [ADC_BITS-1:0]   batload_i_raw_i,
  input  logic [ADC_BITS-1:0]   load_i_raw_i,
  input  logic                  inhibit_i,
  output logic                  item_valid_o,
  input  logic                  item_pop_i,
  output logic [5*ADC_BITS:0]   item_o
);

  localparam int unsigned DEPTH  = mppt_pkg::QUEUE_DEPTH;
  localparam int unsigned ITEM_W = 5 * ADC_BITS + 1;
  localparam int unsigned PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  logic [ITEM_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              wr_en, rd_en;

  assign full_o       = (cnt_q == CNT_W'(DEPTH));
  assign item_valid_o = (cnt_q != '0);
  assign wr_en        = push_i & ~full_o;
  assign rd_en        = item_pop_i & item_valid_o;
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // tag each request with the inhibit state at acceptance
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= {inhibit_i, load_i_raw_i, batload_i_raw_i, batload_v_raw_i,
                          panel_i_raw_i, panel_v_raw_i};
    end
  end

endmodule
`default_nettype wire

[src/mppt_back.sv]
`default_nettype none
module mppt_back #(
  parameter int unsigned ADC_BITS       = mppt_pkg::ADC_BITS_DEF,
  parameter int unsigned DUTY_BITS      = mppt_pkg::DUTY_BITS_DEF,
  parameter int unsigned GAIN_FRAC_BITS = mppt_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              item_valid_i,
  output logic                              item_pop_o,
  input  logic [5*ADC_BITS:0]               item_i,
  input  mppt_pkg::mppt_cfg_t               cfg_i,
  output logic                              res_empty_o,
  input  logic                              res_pop_i,
  output logic [DUTY_BITS-1:0]              duty_cycle_o,
  output logic                              gate_enable_o,
  output logic [mppt_pkg::MEAS_W-1:0]       panel_mv_o,
  output logic [mppt_pkg::MEAS_W-1:0]       panel_ma_o,
  output logic [mppt_pkg::POWER_W-1:0]      panel_power_o,
  output logic [mppt_pkg::MEAS_W-1:0]       batload_mv_o,
  output logic signed [mppt_pkg::NET_W-1:0] battery_net_ma_o,
  output logic [mppt_pkg::MEAS_W-1:0]       load_ma_o
);

  localparam int unsigned MW    = mppt_pkg::MEAS_W;
  localparam int unsigned PW    = mppt_pkg::POWER_W;
  localparam int unsigned NW    = mppt_pkg::NET_W;
  localparam int unsigned RAW_W = 5 * ADC_BITS;

  localparam logic [2:0] CH_PANEL_V   = 3'd0;
  localparam logic [2:0] CH_PANEL_I   = 3'd1;
  localparam logic [2:0] CH_BATLOAD_V = 3'd2;
  localparam logic [2:0] CH_BATLOAD_I = 3'd3;
  localparam logic [2:0] CH_LOAD_I    = 3'd4;
  localparam logic [2:0] CH_POWER     = 3'd5;
  localparam logic [2:0] CH_DONE      = 3'd6;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_CALC   = 3'b010,
    ST_DECIDE = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [2:0]       step_q, step_d, wb_idx;
  logic [RAW_W-1:0] raw_q;
  logic             inh_q;
  logic [PW-1:0]    prod_q, prod_shr;
  logic [MW-1:0]    op_a, op_b, sat_val;
  logic [MW-1:0]    scl_q [5];
  logic [PW-1:0]    pw_q;

  logic [DUTY_BITS-1:0] duty_q, duty_nxt;
  logic [MW-1:0]        prev_mv_q, held_pi_q, held_bv_q, held_li_q;
  logic [PW-1:0]        prev_pw_q;
  logic signed [NW-1:0] held_net_q, net;

  logic                 out_valid_q, out_valid_d, out_load;
  logic [DUTY_BITS-1:0] out_duty_q;
  logic                 out_gate_q;
  logic [MW-1:0]        out_mv_q, out_ma_q, out_bv_q, out_li_q;
  logic [PW-1:0]        out_pw_q;
  logic signed [NW-1:0] out_net_q;

  logic over_i, over_v, p_up, p_dn, v_up, v_dn, step_dn, step_up;

  assign item_pop_o = (state_q == ST_IDLE) && item_valid_i;
  assign out_load   = (state_q == ST_DECIDE) && (!out_valid_q || res_pop_i);
  assign wb_idx     = step_q - 3'd1;

  // shared multiplier operand select
  always_comb begin
    case (step_q)
      CH_PANEL_V: begin
        op_a = MW'(raw_q[ADC_BITS-1:0]);
        op_b = cfg_i.panel_v_gain;
      end
      CH_PANEL_I: begin
        op_a = MW'(raw_q[2*ADC_BITS-1:ADC_BITS]);
        op_b = cfg_i.current_gain;
      end
      CH_BATLOAD_V: begin
        op_a = MW'(raw_q[3*ADC_BITS-1:2*ADC_BITS]);
        op_b = cfg_i.batload_v_gain;
      end
      CH_BATLOAD_I: begin
        op_a = MW'(raw_q[4*ADC_BITS-1:3*ADC_BITS]);
        op_b = cfg_i.current_gain;
      end
      CH_LOAD_I: begin
        op_a = MW'(raw_q[5*ADC_BITS-1:4*ADC_BITS]);
        op_b = cfg_i.current_gain;
      end
      CH_POWER: begin
        op_a = scl_q[0];
        op_b = scl_q[1];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_shr = prod_q >> GAIN_FRAC_BITS;
  assign sat_val  = (|prod_shr[PW-1:MW]) ? '1 : prod_shr[MW-1:0];

  // decision on the scaled sample
  assign net    = $signed({1'b0, scl_q[3]}) - $signed({1'b0, scl_q[4]});
  assign over_i = net > $signed({1'b0, cfg_i.battery_i_limit});
  assign over_v = scl_q[2] > cfg_i.battery_v_limit;
  assign p_up   = pw_q > prev_pw_q;
  assign p_dn   = pw_q < prev_pw_q;
  assign v_up   = scl_q[0] > prev_mv_q;
  assign v_dn   = scl_q[0] < prev_mv_q;
  assign step_dn = over_i | over_v | (p_up & v_up) | (p_dn & v_dn);
  assign step_up = ~(over_i | over_v) & ((p_dn & v_up) | (p_up & v_dn));

  always_comb begin
    duty_nxt = duty_q;
    if (step_dn && duty_q != '0) begin
      duty_nxt = duty_q - DUTY_BITS'(1);
    end else if (step_up && duty_q != '1) begin
      duty_nxt = duty_q + DUTY_BITS'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    unique case (state_q)
      ST_IDLE: begin
        step_d = CH_PANEL_V;
        if (item_valid_i) begin
          state_d = item_i[RAW_W] ? ST_DECIDE : ST_CALC;
        end
      end
      ST_CALC: begin
        step_d = step_q + 3'd1;
        if (step_q == CH_DONE) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = out_load | (out_valid_q & ~res_pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      duty_q      <= '0;
      prev_mv_q   <= '0;
      prev_pw_q   <= '0;
      held_pi_q   <= '0;
      held_bv_q   <= '0;
      held_net_q  <= '0;
      held_li_q   <= '0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (out_load && !inh_q) begin
        duty_q     <= duty_nxt;
        prev_mv_q  <= scl_q[0];
        prev_pw_q  <= pw_q;
        held_pi_q  <= scl_q[1];
        held_bv_q  <= scl_q[2];
        held_net_q <= net;
        held_li_q  <= scl_q[4];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      raw_q <= item_i[RAW_W-1:0];
      inh_q <= item_i[RAW_W];
    end
    if (state_q == ST_CALC) begin
      prod_q <= PW'(op_a) * PW'(op_b);
      if (step_q != CH_PANEL_V) begin
        if (wb_idx == CH_POWER) begin
          pw_q <= prod_q;
        end else if (wb_idx != CH_DONE && wb_idx != 3'd7) begin
          scl_q[wb_idx] <= sat_val;
        end
      end
    end
    if (out_load) begin
      if (inh_q) begin
        out_duty_q <= '0;
        out_gate_q <= 1'b0;
        out_mv_q   <= prev_mv_q;
        out_ma_q   <= held_pi_q;
        out_pw_q   <= prev_pw_q;
        out_bv_q   <= held_bv_q;
        out_net_q  <= held_net_q;
        out_li_q   <= held_li_q;
      end else begin
        out_duty_q <= duty_nxt;
        out_gate_q <= (duty_nxt != '0);
        out_mv_q   <= scl_q[0];
        out_ma_q   <= scl_q[1];
        out_pw_q   <= pw_q;
        out_bv_q   <= scl_q[2];
        out_net_q  <= net;
        out_li_q   <= scl_q[4];
      end
    end
  end

  assign res_empty_o      = ~out_valid_q;
  assign duty_cycle_o     = out_duty_q;
  assign gate_enable_o    = out_gate_q;
  assign panel_mv_o       = out_mv_q;
  assign panel_ma_o       = out_ma_q;
  assign panel_power_o    = out_pw_q;
  assign batload_mv_o     = out_bv_q;
  assign battery_net_ma_o = out_net_q;
  assign load_ma_o        = out_li_q;

endmodule
`default_nettype wire

[src/mppt_perturb_observe_duty.sv]
`default_nettype none
// Perturb-and-observe duty controller. Each request carries five raw ADC counts; the block
// scales them by the gain registers to mV and mA, forms panel power and net battery current,
// and steps a saturating duty down on battery overcurrent or overvoltage, otherwise toward
// the maximum power point. One result comes back per request, in order. In the back end one
// 16x16 multiplier is shared over the five scalings and the power product, then the decide
// state steps the duty; an inhibited request skips the multiplier and goes straight to the
// decide state. Two requests queue ahead of the back end and one finished result waits in the
// output register; the decision waits while that register is held. While
// charge_inhibit is set a request yields duty 0 and the stored measurements, and no state
// changes. Write the configuration registers (byte address 4*index) only while no request
// is outstanding.
module mppt_perturb_observe_duty #(
  parameter int unsigned ADC_BITS       = mppt_pkg::ADC_BITS_DEF,
  parameter int unsigned DUTY_BITS      = mppt_pkg::DUTY_BITS_DEF,
  parameter int unsigned GAIN_FRAC_BITS = mppt_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   push,
  output logic                                   full,
  input  logic [ADC_BITS-1:0]                    panel_v_raw_i,
  input  logic [ADC_BITS-1:0]                    panel_i_raw_i,
  input  logic [ADC_BITS-1:0]                    batload_v_raw_i,
  input  logic [ADC_BITS-1:0]                    batload_i_raw_i,
  input  logic [ADC_BITS-1:0]                    load_i_raw_i,
  output logic                                   empty,
  input  logic                                   pop,
  output logic [DUTY_BITS-1:0]                   duty_cycle_o,
  output logic                                   gate_enable_o,
  output logic [mppt_pkg::MEAS_W-1:0]            panel_mv_o,
  output logic [mppt_pkg::MEAS_W-1:0]            panel_ma_o,
  output logic [mppt_pkg::POWER_W-1:0]           panel_power_o,
  output logic [mppt_pkg::MEAS_W-1:0]            batload_mv_o,
  output logic signed [mppt_pkg::NET_W-1:0]      battery_net_ma_o,
  output logic [mppt_pkg::MEAS_W-1:0]            load_ma_o,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [mppt_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [mppt_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [mppt_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                   pready
);

  localparam int unsigned MW = mppt_pkg::MEAS_W;
  localparam int unsigned DW = mppt_pkg::APB_DATA_W;

  mppt_pkg::mppt_cfg_t               cfg_q;
  logic                              inhibit_q;
  logic                              cfg_wr;
  logic [mppt_pkg::REG_IDX_W-1:0]    reg_idx;

  logic                  item_valid, item_pop;
  logic [5*ADC_BITS:0]   item;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = paddr[mppt_pkg::APB_ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.panel_v_gain    <= mppt_pkg::GAIN_RESET;
      cfg_q.batload_v_gain  <= mppt_pkg::GAIN_RESET;
      cfg_q.current_gain    <= mppt_pkg::GAIN_RESET;
      cfg_q.battery_v_limit <= mppt_pkg::LIMIT_RESET;
      cfg_q.battery_i_limit <= mppt_pkg::LIMIT_RESET;
      inhibit_q             <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        mppt_pkg::REG_PANEL_V_GAIN:    cfg_q.panel_v_gain    <= pwdata[MW-1:0];
        mppt_pkg::REG_BATLOAD_V_GAIN:  cfg_q.batload_v_gain  <= pwdata[MW-1:0];
        mppt_pkg::REG_CURRENT_GAIN:    cfg_q.current_gain    <= pwdata[MW-1:0];
        mppt_pkg::REG_BATTERY_V_LIMIT: cfg_q.battery_v_limit <= pwdata[MW-1:0];
        mppt_pkg::REG_BATTERY_I_LIMIT: cfg_q.battery_i_limit <= pwdata[MW-1:0];
        mppt_pkg::REG_CHARGE_INHIBIT:  inhibit_q             <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mppt_pkg::REG_PANEL_V_GAIN:    prdata = DW'(cfg_q.panel_v_gain);
      mppt_pkg::REG_BATLOAD_V_GAIN:  prdata = DW'(cfg_q.batload_v_gain);
      mppt_pkg::REG_CURRENT_GAIN:    prdata = DW'(cfg_q.current_gain);
      mppt_pkg::REG_BATTERY_V_LIMIT: prdata = DW'(cfg_q.battery_v_limit);
      mppt_pkg::REG_BATTERY_I_LIMIT: prdata = DW'(cfg_q.battery_i_limit);
      mppt_pkg::REG_CHARGE_INHIBIT:  prdata = DW'(inhibit_q);
      default:                       prdata = '0;
    endcase
  end

  mppt_front #(
    .ADC_BITS(ADC_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .panel_v_raw_i  (panel_v_raw_i),
    .panel_i_raw_i  (panel_i_raw_i),
    .batload_v_raw_i(batload_v_raw_i),
    .batload_i_raw_i(batload_i_raw_i),
    .load_i_raw_i   (load_i_raw_i),
    .inhibit_i      (inhibit_q),
    .item_valid_o   (item_valid),
    .item_pop_i     (item_pop),
    .item_o         (item)
  );

  mppt_back #(
    .ADC_BITS      (ADC_BITS),
    .DUTY_BITS     (DUTY_BITS),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (item_valid),
    .item_pop_o      (item_pop),
    .item_i          (item),
    .cfg_i           (cfg_q),
    .res_empty_o     (empty),
    .res_pop_i       (pop),
    .duty_cycle_o    (duty_cycle_o),
    .gate_enable_o   (gate_enable_o),
    .panel_mv_o      (panel_mv_o),
    .panel_ma_o      (panel_ma_o),
    .panel_power_o   (panel_power_o),
    .batload_mv_o    (batload_mv_o),
    .battery_net_ma_o(battery_net_ma_o),
    .load_ma_o       (load_ma_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (gate_enable_o == (duty_cycle_o != '0)))
    else $error("gate enable disagrees with duty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop |-> item_valid)
    else $error("back end took from an empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("waiting result dropped");

endmodule
`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned ADC_W   = mppt_pkg::ADC_BITS_DEF;
  localparam int unsigned DUTY_W  = mppt_pkg::DUTY_BITS_DEF;
  localparam int unsigned FRAC_W  = mppt_pkg::GAIN_FRAC_BITS_DEF;
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          HOLD_CYCLES    = 400;
  localparam int          PHASE_ITEMS    = 70;
  localparam int          CLIMB_ITEMS    = 40;

  typedef struct packed {
    logic [ADC_W-1:0] panel_v;
    logic [ADC_W-1:0] panel_i;
    logic [ADC_W-1:0] batload_v;
    logic [ADC_W-1:0] batload_i;
    logic [ADC_W-1:0] load_i;
  } sample_t;

  typedef struct packed {
    logic [DUTY_W-1:0]                  duty;
    logic                               gate;
    logic [mppt_pkg::MEAS_W-1:0]        panel_mv;
    logic [mppt_pkg::MEAS_W-1:0]        panel_ma;
    logic [mppt_pkg::POWER_W-1:0]       power;
    logic [mppt_pkg::MEAS_W-1:0]        batload_mv;
    logic signed [mppt_pkg::NET_W-1:0]  net_ma;
    logic [mppt_pkg::MEAS_W-1:0]        load_ma;
  } reading_t;

  class duty_tracker;
    logic [mppt_pkg::MEAS_W-1:0]       v_gain, bl_gain, i_gain, v_limit, i_limit;
    bit                                inhibit;
    logic [DUTY_W-1:0]                 duty;
    logic [mppt_pkg::MEAS_W-1:0]       last_mv, held_ma, held_bl_mv, held_load_ma;
    logic [mppt_pkg::POWER_W-1:0]      last_power;
    logic signed [mppt_pkg::NET_W-1:0] held_net;
    reading_t                          pending_readings[$];
    int                                errors;

    function new();
      v_gain       = mppt_pkg::GAIN_RESET;
      bl_gain      = mppt_pkg::GAIN_RESET;
      i_gain       = mppt_pkg::GAIN_RESET;
      v_limit      = mppt_pkg::LIMIT_RESET;
      i_limit      = mppt_pkg::LIMIT_RESET;
      inhibit      = 1'b0;
      duty         = '0;
      last_mv      = '0;
      held_ma      = '0;
      held_bl_mv   = '0;
      held_load_ma = '0;
      last_power   = '0;
      held_net     = '0;
      errors       = 0;
    endfunction

    function void set_reg(logic [mppt_pkg::REG_IDX_W-1:0] idx,
                          logic [mppt_pkg::APB_DATA_W-1:0] val);
      case (idx)
        mppt_pkg::REG_PANEL_V_GAIN:    v_gain  = val[mppt_pkg::MEAS_W-1:0];
        mppt_pkg::REG_BATLOAD_V_GAIN:  bl_gain = val[mppt_pkg::MEAS_W-1:0];
        mppt_pkg::REG_CURRENT_GAIN:    i_gain  = val[mppt_pkg::MEAS_W-1:0];
        mppt_pkg::REG_BATTERY_V_LIMIT: v_limit = val[mppt_pkg::MEAS_W-1:0];
        mppt_pkg::REG_BATTERY_I_LIMIT: i_limit = val[mppt_pkg::MEAS_W-1:0];
        mppt_pkg::REG_CHARGE_INHIBIT:  inhibit = val[0];
        default: ;
      endcase
    endfunction

    function logic [mppt_pkg::MEAS_W-1:0] to_units(logic [ADC_W-1:0] raw,
                                                   logic [mppt_pkg::MEAS_W-1:0] gain);
      longint unsigned v;
      v = (longint'(raw) * longint'(gain)) >> FRAC_W;
      return (v > 65535) ? '1 : v[mppt_pkg::MEAS_W-1:0];
    endfunction

    function void note_sample(sample_t s);
      reading_t                     r;
      logic [mppt_pkg::MEAS_W-1:0]  pv, pi, bv, bi, li;
      logic [mppt_pkg::POWER_W-1:0] pw;
      int                           net;
      int                           dir;
      if (!inhibit) begin
        pv  = to_units(s.panel_v, v_gain);
        pi  = to_units(s.panel_i, i_gain);
        bv  = to_units(s.batload_v, bl_gain);
        bi  = to_units(s.batload_i, i_gain);
        li  = to_units(s.load_i, i_gain);
        pw  = mppt_pkg::POWER_W'(pv) * mppt_pkg::POWER_W'(pi);
        net = int'(bi) - int'(li);
        dir = 0;
        if (net > int'(i_limit)) dir = -1;
        else if (bv > v_limit) dir = -1;
        else if (pw > last_power && pv > last_mv) dir = -1;
        else if (pw < last_power && pv > last_mv) dir = 1;
        else if (pw > last_power && pv < last_mv) dir = 1;
        else if (pw < last_power && pv < last_mv) dir = -1;
        if (dir < 0 && duty != '0) duty = duty - 1'b1;
        else if (dir > 0 && duty != '1) duty = duty + 1'b1;
        last_mv      = pv;
        last_power   = pw;
        held_ma      = pi;
        held_bl_mv   = bv;
        held_net     = net[mppt_pkg::NET_W-1:0];
        held_load_ma = li;
      end
      r.duty       = inhibit ? '0 : duty;
      r.gate       = (r.duty != '0);
      r.panel_mv   = last_mv;
      r.panel_ma   = held_ma;
      r.power      = last_power;
      r.batload_mv = held_bl_mv;
      r.net_ma     = held_net;
      r.load_ma    = held_load_ma;
      pending_readings.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task compare(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
    endtask

    task check_reading(reading_t got);
      reading_t want;
      if (pending_readings.size() == 0) begin
        report("result with no request outstanding");
      end else begin
        want = pending_readings.pop_front();
        compare("duty_cycle", got.duty, want.duty);
        compare("gate_enable", got.gate, want.gate);
        compare("panel_mv", got.panel_mv, want.panel_mv);
        compare("panel_ma", got.panel_ma, want.panel_ma);
        compare("panel_power", got.power, want.power);
        compare("batload_mv", got.batload_mv, want.batload_mv);
        compare("battery_net_ma", got.net_ma, want.net_ma);
        compare("load_ma", got.load_ma, want.load_ma);
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty;
  logic [ADC_W-1:0] pv_raw = '0, pi_raw = '0, bv_raw = '0, bi_raw = '0, li_raw = '0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [mppt_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [mppt_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [mppt_pkg::APB_DATA_W-1:0] prdata;
  logic pready;
  logic [DUTY_W-1:0]                 duty_cycle;
  logic                              gate_enable;
  logic [mppt_pkg::MEAS_W-1:0]       panel_mv, panel_ma, batload_mv, load_ma;
  logic [mppt_pkg::POWER_W-1:0]      panel_power;
  logic signed [mppt_pkg::NET_W-1:0] battery_net_ma;

  duty_tracker trk = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_off_req = 1'b0;
  int hold_cnt = 0;

  mppt_perturb_observe_duty u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .panel_v_raw_i    (pv_raw),
    .panel_i_raw_i    (pi_raw),
    .batload_v_raw_i  (bv_raw),
    .batload_i_raw_i  (bi_raw),
    .load_i_raw_i     (li_raw),
    .empty            (empty),
    .pop              (pop),
    .duty_cycle_o     (duty_cycle),
    .gate_enable_o    (gate_enable),
    .panel_mv_o       (panel_mv),
    .panel_ma_o       (panel_ma),
    .panel_power_o    (panel_power),
    .batload_mv_o     (batload_mv),
    .battery_net_ma_o (battery_net_ma),
    .load_ma_o        (load_ma),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic sample_t mk(int a, int b, int c, int d, int e);
    sample_t s;
    s.panel_v   = a[ADC_W-1:0];
    s.panel_i   = b[ADC_W-1:0];
    s.batload_v = c[ADC_W-1:0];
    s.batload_i = d[ADC_W-1:0];
    s.load_i    = e[ADC_W-1:0];
    return s;
  endfunction

  function automatic logic [ADC_W-1:0] nudge(logic [ADC_W-1:0] x);
    int v;
    v = int'(x) + int'($urandom_range(64)) - 32;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[ADC_W-1:0];
  endfunction

  function automatic logic [ADC_W-1:0] rail();
    return $urandom_range(1) ? '1 : '0;
  endfunction

  function automatic sample_t vary(sample_t prev);
    sample_t s;
    int      r;
    r = $urandom_range(99);
    if (r < 25) begin
      s = mk($urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (r < 35) begin
      s.panel_v   = rail();
      s.panel_i   = rail();
      s.batload_v = rail();
      s.batload_i = rail();
      s.load_i    = rail();
    end else begin
      s.panel_v   = nudge(prev.panel_v);
      s.panel_i   = nudge(prev.panel_i);
      s.batload_v = nudge(prev.batload_v);
      s.batload_i = nudge(prev.batload_i);
      s.load_i    = nudge(prev.load_i);
    end
    return s;
  endfunction

  function automatic logic [mppt_pkg::MEAS_W-1:0] pick_gain();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 7) return mppt_pkg::MEAS_W'($urandom_range(3000, 6000));
    return mppt_pkg::MEAS_W'($urandom);
  endfunction

  function automatic logic [mppt_pkg::MEAS_W-1:0] pick_limit();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 7) return mppt_pkg::MEAS_W'($urandom_range(0, 6000));
    return mppt_pkg::MEAS_W'($urandom);
  endfunction

  task automatic write_reg(logic [mppt_pkg::REG_IDX_W-1:0] idx,
                           logic [mppt_pkg::APB_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    trk.set_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic send_sample(sample_t s);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push   <= 1'b1;
    pv_raw <= s.panel_v;
    pi_raw <= s.panel_i;
    bv_raw <= s.batload_v;
    bi_raw <= s.batload_i;
    li_raw <= s.load_i;
    do @(posedge clk_i); while (full);
    trk.note_sample(s);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (trk.pending_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic restore_defaults();
    write_reg(mppt_pkg::REG_PANEL_V_GAIN, mppt_pkg::GAIN_RESET);
    write_reg(mppt_pkg::REG_BATLOAD_V_GAIN, mppt_pkg::GAIN_RESET);
    write_reg(mppt_pkg::REG_CURRENT_GAIN, mppt_pkg::GAIN_RESET);
    write_reg(mppt_pkg::REG_BATTERY_V_LIMIT, mppt_pkg::LIMIT_RESET);
    write_reg(mppt_pkg::REG_BATTERY_I_LIMIT, mppt_pkg::LIMIT_RESET);
    write_reg(mppt_pkg::REG_CHARGE_INHIBIT, '0);
  endtask

  // Result side: check accepted results, then decide pop for the next edge.
  initial begin
    reading_t got;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        got.duty       = duty_cycle;
        got.gate       = gate_enable;
        got.panel_mv   = panel_mv;
        got.panel_ma   = panel_ma;
        got.power      = panel_power;
        got.batload_mv = batload_mv;
        got.net_ma     = battery_net_ma;
        got.load_ma    = load_ma;
        trk.check_reading(got);
      end
      if (hold_off_req && hold_cnt < HOLD_CYCLES) begin
        hold_cnt++;
        pop <= 1'b0;
      end else begin
        pop <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int stalled;
    stalled = 0;
    wait (rst_ni === 1'b1);
    while (stalled < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) stalled = 0;
      else stalled++;
    end
    $display("[mppt_perturb_observe_duty] ERROR");
    $finish;
  end

  initial begin
    sample_t last;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 15;
    recv_idle_pct = 88;

    // Directed: rails, equal changes, each perturb-and-observe quadrant, floor clamp.
    send_sample(mk(0, 0, 0, 0, 0));
    send_sample(mk(4095, 4095, 4095, 4095, 4095));
    send_sample(mk(4095, 4095, 4095, 4095, 4095));
    send_sample(mk(100, 4000, 0, 0, 0));
    send_sample(mk(4000, 50, 0, 0, 0));
    send_sample(mk(100, 4000, 0, 0, 0));
    send_sample(mk(4000, 50, 0, 0, 0));
    send_sample(mk(4000, 60, 0, 0, 0));
    send_sample(mk(3000, 80, 0, 0, 0));
    send_sample(mk('hAAA, 'h555, 'hAAA, 'h555, 'hAAA));
    send_sample(mk('h555, 'hAAA, 'h555, 'hAAA, 'h555));
    send_sample(mk(2000, 100, 0, 0, 4095));
    drain();

    // Overcurrent, and the boundary on the limit.
    write_reg(mppt_pkg::REG_BATTERY_I_LIMIT, 100);
    send_sample(mk(2000, 100, 0, 4095, 0));
    send_sample(mk(2000, 100, 0, 200, 100));
    send_sample(mk(2000, 100, 0, 101, 0));
    drain();

    // Overvoltage at and above the limit; then overcurrent at limit zero, with the voltage at its limit.
    write_reg(mppt_pkg::REG_BATTERY_I_LIMIT, mppt_pkg::LIMIT_RESET);
    write_reg(mppt_pkg::REG_BATTERY_V_LIMIT, 1000);
    send_sample(mk(2000, 100, 1001, 0, 0));
    send_sample(mk(2000, 100, 1000, 0, 0));
    drain();
    write_reg(mppt_pkg::REG_BATTERY_I_LIMIT, '0);
    send_sample(mk(2000, 100, 1000, 1, 0));
    send_sample(mk(2000, 100, 1000, 0, 0));
    drain();

    // Inhibit: duty zero, stored values repeat, inputs ignored.
    write_reg(mppt_pkg::REG_CHARGE_INHIBIT, 1);
    send_sample(mk(4095, 4095, 4095, 4095, 0));
    send_sample(mk(0, 0, 0, 0, 4095));
    drain();

    write_reg(mppt_pkg::REG_CHARGE_INHIBIT, '0);
    write_reg(mppt_pkg::REG_BATTERY_I_LIMIT, mppt_pkg::LIMIT_RESET);
    write_reg(mppt_pkg::REG_BATTERY_V_LIMIT, mppt_pkg::LIMIT_RESET);
    write_reg(mppt_pkg::REG_PANEL_V_GAIN, '0);
    write_reg(mppt_pkg::REG_BATLOAD_V_GAIN, '0);
    write_reg(mppt_pkg::REG_CURRENT_GAIN, '0);
    send_sample(mk(4095, 4095, 4095, 4095, 4095));
    drain();
    write_reg(mppt_pkg::REG_PANEL_V_GAIN, '1);
    write_reg(mppt_pkg::REG_BATLOAD_V_GAIN, '1);
    write_reg(mppt_pkg::REG_CURRENT_GAIN, '1);
    send_sample(mk(4095, 4095, 4095, 4095, 4095));
    send_sample(mk(4095, 4095, 4095, 0, 4095));
    drain();

    // Random phases, each under a fresh register setting.
    last = mk(2000, 1000, 2000, 500, 500);
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) begin
        send_idle_pct = 88;
        recv_idle_pct = 15;
      end else if (ph == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(mppt_pkg::REG_PANEL_V_GAIN, pick_gain());
      write_reg(mppt_pkg::REG_BATLOAD_V_GAIN, pick_gain());
      write_reg(mppt_pkg::REG_CURRENT_GAIN, pick_gain());
      write_reg(mppt_pkg::REG_BATTERY_V_LIMIT, pick_limit());
      write_reg(mppt_pkg::REG_BATTERY_I_LIMIT, pick_limit());
      write_reg(mppt_pkg::REG_CHARGE_INHIBIT, ($urandom_range(7) == 0));
      if (ph == 1) hold_off_req = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        last = vary(last);
        send_sample(last);
      end
      drain();
    end

    // Climb: alternate two points so every step after the first goes up.
    restore_defaults();
    for (int k = 0; k < CLIMB_ITEMS; k++) begin
      if (k % 2 == 0) send_sample(mk(4000, 50, $urandom, $urandom, $urandom));
      else send_sample(mk(100, 4000, $urandom, $urandom, $urandom));
    end
    drain();

    repeat (30) @(posedge clk_i);
    if (trk.errors == 0 && trk.pending_readings.size() == 0)
      $display("[mppt_perturb_observe_duty] OK");
    else
      $display("[mppt_perturb_observe_duty] ERROR");
    $finish;
  end

endmodule

[sim.f]
src/mppt_pkg.sv
src/mppt_front.sv
src/mppt_back.sv
src/mppt_perturb_observe_duty.sv
test/testbench.sv
